/* hw/rtl/onv_pkg.sv */
package onv_pkg;

	localparam int GRID_SIZE_DEF = 64;

	// field widths
	localparam int COORD_W     = 6;
	localparam int COORD_MAX_W = 8;
	localparam int SEED_W      = 16;
	localparam int OCT_CNT_W   = 3;
	localparam int BIAS_W      = 12;
	localparam int BIAS_FRAC   = 8;
	localparam int STEP_W      = 16;
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 16;

	// datapath widths, sized for the largest grid
	localparam int TOP_W   = 24;
	localparam int MIX_W   = 32;
	localparam int W_W     = 17;
	localparam int ACC_W   = 36;
	localparam int WSUM_W  = 20;
	localparam int MAC_B_W = 17;
	localparam int SUB_W   = 3;

	// divider: quotient always fits 17 bits in every use
	localparam int DIV_Q_W   = 17;
	localparam int DIV_D_W   = 20;
	localparam int DIV_CNT_W = 5;

	localparam logic [CFG_IDX_W-1:0] REG_OCTAVE_COUNT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BIAS         = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_QUANT_STEP   = 2'd2;

	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_EVAL  = 1'b1;

	localparam logic [OCT_CNT_W-1:0] OCT_RESET  = 3'd5;
	localparam logic [BIAS_W-1:0]    BIAS_RESET = 12'd512;
	localparam logic [BIAS_W-1:0]    BIAS_MIN   = 12'd256;
	localparam logic [STEP_W-1:0]    STEP_RESET = 16'd3277;
	localparam logic [W_W-1:0]       W_ONE      = 17'h10000;
	localparam logic [SUB_W-1:0]     SUB_LAST   = 3'd4;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_READ,
		ST_TOP0,
		ST_TOP1,
		ST_MIX0,
		ST_BOT0,
		ST_BOT1,
		ST_MIX1,
		ST_ACC,
		ST_WDIV,
		ST_WWAIT,
		ST_NDIV,
		ST_NWAIT,
		ST_QDIV,
		ST_QWAIT
	} state_t;

	typedef struct packed {
		logic               start;
		logic [DIV_D_W-1:0] rem_init;
		logic [DIV_Q_W-1:0] low;
		logic [DIV_D_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic               done;
		logic [DIV_Q_W-1:0] quo;
		logic [DIV_D_W-1:0] rem;
	} div_rsp_t;

endpackage

/* hw/rtl/onv_seed_ram.sv */
module onv_seed_ram import onv_pkg::*; #(
	parameter int AW = 12
) (
	input  logic              clk,
	input  logic              we,
	input  logic [AW-1:0]     waddr,
	input  logic [SEED_W-1:0] wdata,
	input  logic [AW-1:0]     raddr,
	output logic [SEED_W-1:0] rdata
);

	logic [SEED_W-1:0] mem [2**AW];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

/* hw/rtl/onv_mac.sv */
module onv_mac import onv_pkg::*; (
	input  logic [TOP_W-1:0]   a,
	input  logic [MAC_B_W-1:0] b,
	input  logic [ACC_W-1:0]   addend,
	output logic [ACC_W-1:0]   y
);

	logic [TOP_W+MAC_B_W-1:0] prod;

	assign prod = a * b;
	assign y    = addend + prod[ACC_W-1:0];

endmodule

/* hw/rtl/onv_div.sv */
module onv_div import onv_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	logic [DIV_D_W-1:0]   rem_q;
	logic [DIV_Q_W-1:0]   quo_q;
	logic [DIV_D_W-1:0]   d_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic                 run_q;
	logic                 done_q;

	logic [DIV_D_W:0] trial;
	logic [DIV_D_W:0] diff;
	logic             ge;

	// restoring, one quotient bit per cycle; rem_init must already be below the divisor
	assign trial = {rem_q, quo_q[DIV_Q_W-1]};
	assign diff  = trial - {1'b0, d_q};
	assign ge    = trial >= {1'b0, d_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				run_q <= 1'b1;
				cnt_q <= DIV_CNT_W'(DIV_Q_W);
			end else if (run_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == DIV_CNT_W'(1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= req.rem_init;
			quo_q <= req.low;
			d_q   <= req.divisor;
		end else if (run_q) begin
			rem_q <= ge ? diff[DIV_D_W-1:0] : trial[DIV_D_W-1:0];
			quo_q <= {quo_q[DIV_Q_W-2:0], ge};
		end
	end

	assign rsp.done = done_q;
	assign rsp.quo  = quo_q;
	assign rsp.rem  = rem_q;

endmodule

/* hw/rtl/octave_value_noise_2d.sv */
// Seed write: written into the grid on accept, busy is not raised.
// Evaluate: per octave (n = octaves summed), four corner reads and multiply-accumulates,
// then divisions on the one radix-2 divider: n-1 weight updates, the normalize and the
// quantize. One item at a time.
// height is valid with the one-cycle done strobe and held after it; the receiver cannot stall.
// Reset clears the sequencer and the registers to 5 octaves, bias 2.0, step 3277;
// the seed grid is not cleared.
module octave_value_noise_2d import onv_pkg::*; #(
	parameter int GRID_SIZE = GRID_SIZE_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	input  logic                  op,
	input  logic [COORD_W-1:0]    col,
	input  logic [COORD_W-1:0]    row,
	input  logic [SEED_W-1:0]     seed_value,
	output logic                  done,
	output logic [SEED_W-1:0]     height,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int GW = $clog2(GRID_SIZE);
	localparam int PW = GW + 1;
	localparam int OW = $clog2(GW + 2);
	localparam int AW = 2 * GW;

	state_t st_q, st_d;

	logic [OCT_CNT_W-1:0] oct_q;
	logic [BIAS_W-1:0]    bias_q;
	logic [STEP_W-1:0]    step_q;

	logic [GW-1:0]        x_q, y_q;
	logic [OW-1:0]        o_q;
	logic [SUB_W-1:0]     sub_q;
	logic [SEED_W-1:0]    c_q [4];
	logic [TOP_W-1:0]     t_q;
	logic [MIX_W-1:0]     m_q;
	logic [ACC_W-1:0]     acc_q;
	logic [WSUM_W-1:0]    wsum_q;
	logic [W_W-1:0]       w_q;
	logic [SEED_W-1:0]    v_q;
	logic [SEED_W-1:0]    height_q;
	logic                 done_q;

	logic [COORD_MAX_W-1:0] colx, rowx;
	logic                   accept;
	logic                   ram_we;
	logic [SEED_W-1:0]      rdata;
	logic [AW-1:0]          raddr;

	logic [PW-1:0] p, pm_full, dx, dy, pdx, pdy;
	logic [GW-1:0] pm, x1, x2, y1, y2;
	logic [3:0]    lg_p;
	logic [MIX_W-1:0] mix_sh;
	logic [SEED_W-1:0] sample;
	logic [OCT_CNT_W-1:0] cnt_eff;
	logic [3:0]    last_raw, o_last;
	logic          is_last;
	logic [BIAS_W-1:0] bias_eff;
	logic [STEP_W-1:0] step_eff;
	logic [1:0]    cidx;
	logic [W_W+BIAS_FRAC-1:0] wdiv_dvd;

	logic [TOP_W-1:0]   mac_a;
	logic [MAC_B_W-1:0] mac_b;
	logic [ACC_W-1:0]   mac_add, mac_y;
	div_req_t div_req;
	div_rsp_t div_rsp;

	assign cfg_ready = 1'b1;
	assign busy      = st_q != ST_IDLE;
	assign accept    = start && !busy;
	assign colx      = COORD_MAX_W'(col);
	assign rowx      = COORD_MAX_W'(row);
	assign ram_we    = accept && op == OP_WRITE;
	assign done      = done_q;
	assign height    = height_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			oct_q  <= OCT_RESET;
			bias_q <= BIAS_RESET;
			step_q <= STEP_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_OCTAVE_COUNT: oct_q  <= cfg_data[OCT_CNT_W-1:0];
				REG_BIAS:         bias_q <= cfg_data[BIAS_W-1:0];
				REG_QUANT_STEP:   step_q <= cfg_data[STEP_W-1:0];
				default: ;
			endcase
		end
	end

	// lattice geometry for the current octave; pitch is a power of two
	assign p       = PW'(GRID_SIZE) >> o_q;
	assign pm_full = p - PW'(1);
	assign pm      = pm_full[GW-1:0];
	assign x1      = x_q & ~pm;
	assign y1      = y_q & ~pm;
	assign x2      = x1 + p[GW-1:0];
	assign y2      = y1 + p[GW-1:0];
	assign dx      = {1'b0, x_q & pm};
	assign dy      = {1'b0, y_q & pm};
	assign pdx     = p - dx;
	assign pdy     = p - dy;

	always_comb begin
		case (sub_q)
			3'd0:    raddr = {y1, x1};
			3'd1:    raddr = {y1, x2};
			3'd2:    raddr = {y2, x1};
			default: raddr = {y2, x2};
		endcase
	end

	// divide by pitch squared
	assign lg_p   = 4'(GW) - 4'(o_q);
	assign mix_sh = m_q >> {lg_p, 1'b0};
	assign sample = mix_sh[SEED_W-1:0];

	assign cnt_eff  = (oct_q == '0) ? OCT_CNT_W'(1) : oct_q;
	assign last_raw = 4'(cnt_eff) - 4'd1;
	assign o_last   = (last_raw > 4'(GW)) ? 4'(GW) : last_raw;
	assign is_last  = 4'(o_q) == o_last;
	assign bias_eff = (bias_q < BIAS_MIN) ? BIAS_MIN : bias_q;
	assign step_eff = (step_q == '0) ? STEP_W'(1) : step_q;
	assign cidx     = 2'(sub_q - SUB_W'(1));
	assign wdiv_dvd = {w_q, {BIAS_FRAC{1'b0}}};

	always_comb begin
		st_d    = st_q;
		mac_a   = '0;
		mac_b   = '0;
		mac_add = '0;
		div_req = '0;
		case (st_q)
			ST_IDLE: begin
				if (start && op == OP_EVAL) st_d = ST_READ;
			end
			ST_READ: begin
				if (sub_q == SUB_LAST) st_d = ST_TOP0;
			end
			ST_TOP0: begin
				mac_a = TOP_W'(c_q[0]);
				mac_b = MAC_B_W'(pdx);
				st_d  = ST_TOP1;
			end
			ST_TOP1: begin
				mac_a   = TOP_W'(c_q[1]);
				mac_b   = MAC_B_W'(dx);
				mac_add = ACC_W'(t_q);
				st_d    = ST_MIX0;
			end
			ST_MIX0: begin
				mac_a = t_q;
				mac_b = MAC_B_W'(pdy);
				st_d  = ST_BOT0;
			end
			ST_BOT0: begin
				mac_a = TOP_W'(c_q[2]);
				mac_b = MAC_B_W'(pdx);
				st_d  = ST_BOT1;
			end
			ST_BOT1: begin
				mac_a   = TOP_W'(c_q[3]);
				mac_b   = MAC_B_W'(dx);
				mac_add = ACC_W'(t_q);
				st_d    = ST_MIX1;
			end
			ST_MIX1: begin
				mac_a   = t_q;
				mac_b   = MAC_B_W'(dy);
				mac_add = ACC_W'(m_q);
				st_d    = ST_ACC;
			end
			ST_ACC: begin
				mac_a   = TOP_W'(sample);
				mac_b   = MAC_B_W'(w_q);
				mac_add = acc_q;
				st_d    = is_last ? ST_NDIV : ST_WDIV;
			end
			ST_WDIV: begin
				// next weight = w * 256 / bias
				div_req.start    = 1'b1;
				div_req.rem_init = DIV_D_W'(wdiv_dvd[W_W+BIAS_FRAC-1:DIV_Q_W]);
				div_req.low      = wdiv_dvd[DIV_Q_W-1:0];
				div_req.divisor  = DIV_D_W'(bias_eff);
				st_d             = ST_WWAIT;
			end
			ST_WWAIT: begin
				if (div_rsp.done) st_d = ST_READ;
			end
			ST_NDIV: begin
				div_req.start    = 1'b1;
				div_req.rem_init = DIV_D_W'(acc_q[ACC_W-1:DIV_Q_W]);
				div_req.low      = acc_q[DIV_Q_W-1:0];
				div_req.divisor  = DIV_D_W'(wsum_q);
				st_d             = ST_NWAIT;
			end
			ST_NWAIT: begin
				if (div_rsp.done) st_d = ST_QDIV;
			end
			ST_QDIV: begin
				div_req.start    = 1'b1;
				div_req.rem_init = '0;
				div_req.low      = DIV_Q_W'(v_q);
				div_req.divisor  = DIV_D_W'(step_eff);
				st_d             = ST_QWAIT;
			end
			ST_QWAIT: begin
				if (div_rsp.done) st_d = ST_IDLE;
			end
			default: st_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= ST_IDLE;
			o_q    <= '0;
			sub_q  <= '0;
			done_q <= 1'b0;
		end else begin
			st_q   <= st_d;
			done_q <= st_q == ST_QWAIT && div_rsp.done;
			if (st_q == ST_IDLE) begin
				o_q   <= '0;
				sub_q <= '0;
			end else if (st_q == ST_READ) begin
				sub_q <= sub_q + 1'b1;
			end else if (st_q == ST_WWAIT && div_rsp.done) begin
				o_q   <= o_q + 1'b1;
				sub_q <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (st_q)
			ST_IDLE: begin
				if (accept && op == OP_EVAL) begin
					x_q    <= colx[GW-1:0];
					y_q    <= rowx[GW-1:0];
					w_q    <= W_ONE;
					acc_q  <= '0;
					wsum_q <= '0;
				end
			end
			ST_READ: begin
				// read data arrives in the cycle after its address
				if (sub_q != '0) c_q[cidx] <= rdata;
			end
			ST_TOP0, ST_TOP1, ST_BOT0, ST_BOT1: t_q <= mac_y[TOP_W-1:0];
			ST_MIX0, ST_MIX1: m_q <= mac_y[MIX_W-1:0];
			ST_ACC: begin
				acc_q  <= mac_y;
				wsum_q <= wsum_q + WSUM_W'(w_q);
			end
			ST_WWAIT: begin
				if (div_rsp.done) w_q <= div_rsp.quo[W_W-1:0];
			end
			ST_NWAIT: begin
				if (div_rsp.done) begin
					v_q <= div_rsp.quo[DIV_Q_W-1] ? {SEED_W{1'b1}} : div_rsp.quo[SEED_W-1:0];
				end
			end
			ST_QWAIT: begin
				// floor to a multiple of the step: value minus remainder
				if (div_rsp.done) height_q <= v_q - div_rsp.rem[SEED_W-1:0];
			end
			default: ;
		endcase
	end

	onv_seed_ram #(
		.AW(AW)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr({rowx[GW-1:0], colx[GW-1:0]}),
		.wdata(seed_value),
		.raddr(raddr),
		.rdata(rdata)
	);

	onv_mac u_mac (
		.a     (mac_a),
		.b     (mac_b),
		.addend(mac_add),
		.y     (mac_y)
	);

	onv_div u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (div_req),
		.rsp   (div_rsp)
	);

endmodule

/* dv/tb_octave_value_noise_2d.sv */
module tb_octave_value_noise_2d;
	import onv_pkg::*;

	localparam int GRID  = GRID_SIZE_DEF;
	localparam int SETTLE_CYCLES = 300;  // longest evaluate sums 7 octaves

	// index that maps to no register
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

	typedef struct {
		logic               op;
		logic [COORD_W-1:0] col;
		logic [COORD_W-1:0] row;
		logic [SEED_W-1:0]  seed;
	} noise_item_t;

	logic                  clk        = 1'b0;
	logic                  arst_n     = 1'b0;
	logic                  start      = 1'b0;
	logic                  op         = OP_WRITE;
	logic [COORD_W-1:0]    col        = '0;
	logic [COORD_W-1:0]    row        = '0;
	logic [SEED_W-1:0]     seed_value = '0;
	logic                  cfg_valid  = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index  = REG_OCTAVE_COUNT;
	logic [CFG_DATA_W-1:0] cfg_data   = '0;
	logic                  busy;
	logic                  done;
	logic [SEED_W-1:0]     height;
	logic                  cfg_ready;

	// mirror of the block: seed grid and registers
	logic [SEED_W-1:0]    seed_mirror [GRID*GRID];
	logic [OCT_CNT_W-1:0] oct_cfg  = OCT_RESET;
	logic [BIAS_W-1:0]    bias_cfg = BIAS_RESET;
	logic [STEP_W-1:0]    step_cfg = STEP_RESET;

	// grid entries already scheduled for a write, tracked at generation time
	bit seeded [GRID*GRID];

	noise_item_t       items_pending[$];
	logic [SEED_W-1:0] heights_due[$];

	int errors    = 0;
	int n_writes  = 0;
	int n_evals   = 0;
	int n_phases  = 0;
	int burst_left = 0;
	int gap_left   = 0;
	bit drain_wait = 0;

	octave_value_noise_2d DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.op        (op),
		.col       (col),
		.row       (row),
		.seed_value(seed_value),
		.done      (done),
		.height    (height),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	function automatic int unsigned octaves_used();
		return (oct_cfg == 0) ? 1 : oct_cfg;
	endfunction

	// weighted bilinear sum over the octaves, normalized and floored to the step
	function automatic logic [SEED_W-1:0] predict_height(input logic [COORD_W-1:0] cx,
			input logic [COORD_W-1:0] cy);
		longint unsigned acc, wsum, w, p, x1, y1, x2, y2, dx, dy;
		longint unsigned top, bot, mix, value, bias, stepv;
		int unsigned n, o;
		n     = octaves_used();
		bias  = (bias_cfg < BIAS_MIN) ? BIAS_MIN : bias_cfg;
		stepv = (step_cfg == 0) ? 1 : step_cfg;
		w     = W_ONE;
		acc   = 0;
		wsum  = 0;
		for (o = 0; o < n && o < 16; o++) begin
			p = GRID >> o;
			if (p == 0)
				break;
			x1  = (cx / p) * p;
			y1  = (cy / p) * p;
			x2  = (x1 + p) % GRID;
			y2  = (y1 + p) % GRID;
			dx  = cx - x1;
			dy  = cy - y1;
			top = (p - dx) * seed_mirror[y1*GRID + x1] + dx * seed_mirror[y1*GRID + x2];
			bot = (p - dx) * seed_mirror[y2*GRID + x1] + dx * seed_mirror[y2*GRID + x2];
			mix = (p - dy) * top + dy * bot;
			acc  += (mix / (p * p)) * w;
			wsum += w;
			w = (w * 256) / bias;
		end
		value = acc / wsum;
		if (value > 65535)
			value = 65535;
		return SEED_W'((value / stepv) * stepv);
	endfunction

	function automatic logic [SEED_W-1:0] pick_seed();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return '1;
			default: return SEED_W'($urandom_range(0, 65535));
		endcase
	endfunction

	function automatic void push_write(input int cx, input int cy, input logic [SEED_W-1:0] v);
		noise_item_t it;
		it.op   = OP_WRITE;
		it.col  = COORD_W'(cx);
		it.row  = COORD_W'(cy);
		it.seed = v;
		items_pending.push_back(it);
		seeded[cy*GRID + cx] = 1'b1;
	endfunction

	// seeds every corner the evaluate will read under the current octave count,
	// then queues the evaluate; returns the number of items queued
	function automatic int queue_eval(input int cx, input int cy, input bit fixed_fill,
			input logic [SEED_W-1:0] fill);
		noise_item_t it;
		int p, x1, y1, xx, yy, cnt;
		int unsigned o;
		cnt = 0;
		for (o = 0; o < octaves_used(); o++) begin
			p  = GRID >> o;
			x1 = (cx / p) * p;
			y1 = (cy / p) * p;
			for (int k = 0; k < 4; k++) begin
				xx = k[0] ? (x1 + p) % GRID : x1;
				yy = k[1] ? (y1 + p) % GRID : y1;
				if (!seeded[yy*GRID + xx]) begin
					push_write(xx, yy, fixed_fill ? fill : pick_seed());
					cnt++;
				end
			end
		end
		it.op   = OP_EVAL;
		it.col  = COORD_W'(cx);
		it.row  = COORD_W'(cy);
		it.seed = SEED_W'($urandom_range(0, 65535));
		items_pending.push_back(it);
		return cnt + 1;
	endfunction

	function automatic int pick_coord();
		case ($urandom_range(0, 9))
			0: return 0;
			1: return GRID - 1;
			default: return $urandom_range(0, GRID - 1);
		endcase
	endfunction

	function automatic void queue_random(input int count);
		int queued;
		queued = 0;
		while (queued < count) begin
			if ($urandom_range(0, 99) < 35) begin
				push_write(pick_coord(), pick_coord(), pick_seed());
				queued++;
			end else begin
				queued += queue_eval(pick_coord(), pick_coord(), 1'b0, '0);
			end
		end
	endfunction

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_OCTAVE_COUNT: oct_cfg  = data[OCT_CNT_W-1:0];
			REG_BIAS:         bias_cfg = data[BIAS_W-1:0];
			REG_QUANT_STEP:   step_cfg = data[STEP_W-1:0];
			default: ;
		endcase
		cfg_valid <= 1'b0;
	endtask

	task automatic settle();
		do @(posedge clk);
		while (items_pending.size() != 0 || start || heights_due.size() != 0 || busy);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic run_phase(input logic [CFG_DATA_W-1:0] oc, input logic [CFG_DATA_W-1:0] bs,
			input logic [CFG_DATA_W-1:0] st, input int count);
		write_reg(REG_OCTAVE_COUNT, oc);
		write_reg(REG_BIAS, bs);
		write_reg(REG_QUANT_STEP, st);
		n_phases++;
		queue_random(count);
		settle();
	endtask

	// driver: bursts of items with random gaps, occasionally draining all results first
	always @(posedge clk) begin
		noise_item_t it;
		logic go;
		go = start && busy;
		if (start && !busy) begin
			if (op == OP_WRITE) begin
				seed_mirror[row*GRID + col] = seed_value;
				n_writes++;
			end else begin
				heights_due.push_back(predict_height(col, row));
				n_evals++;
			end
		end
		if (!go && arst_n) begin
			if (drain_wait) begin
				if (heights_due.size() == 0)
					drain_wait = 0;
			end else if (gap_left != 0) begin
				gap_left--;
			end else if (items_pending.size() != 0) begin
				it = items_pending.pop_front();
				op         <= it.op;
				col        <= it.col;
				row        <= it.row;
				seed_value <= it.seed;
				go = 1'b1;
				if (burst_left <= 1) begin
					burst_left = $urandom_range(1, 24);
					gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
					drain_wait = ($urandom_range(0, 39) == 0);
				end else begin
					burst_left--;
				end
			end
		end
		start <= go;
	end

	always @(posedge clk) begin
		logic [SEED_W-1:0] want;
		if (arst_n && done) begin
			if (heights_due.size() == 0) begin
				$error("height: no item waiting, actual %0d", height);
				errors++;
			end else begin
				want = heights_due.pop_front();
				if (height !== want) begin
					$error("height: expected %0d, actual %0d", want, height);
					errors++;
				end
			end
		end
	end

	initial begin
		int dummy;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: all-max corners, all-zero corners overlapping by wrap, edges
		n_phases++;
		dummy = queue_eval(0, 0, 1'b1, '1);
		dummy = queue_eval(GRID - 1, GRID - 1, 1'b1, '0);
		push_write(0, 0, '0);
		dummy = queue_eval(GRID - 1, 0, 1'b0, '0);
		dummy = queue_eval(0, GRID - 1, 1'b0, '0);
		queue_random(150);
		settle();

		// most octaves, weight divisor 1.0, no quantization
		write_reg(REG_OCTAVE_COUNT, 16'd7);
		write_reg(REG_BIAS, 16'd256);
		write_reg(REG_QUANT_STEP, 16'd1);
		n_phases++;
		dummy = queue_eval(0, 0, 1'b0, '0);
		dummy = queue_eval(GRID - 1, GRID - 1, 1'b0, '0);
		dummy = queue_eval(31, 32, 1'b0, '0);
		queue_random(220);
		settle();

		// zero octaves reads as one; unused register index written as well
		write_reg(REG_UNUSED, 16'hFFFF);
		run_phase(16'd0, 16'd4095, 16'hFFFF, 150);
		// bias under 1.0 clamps, step zero means no quantization
		run_phase(16'd1, 16'h00FF, 16'd0, 150);
		run_phase(16'd6, 16'd300, 16'd3277, 120);
		repeat (5)
			run_phase(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
				16'($urandom_range(0, 65535)), 170);

		settle();
		$display("covered %0d seed writes and %0d evaluations over %0d register settings",
			n_writes, n_evals, n_phases);
		if (errors == 0)
			$display("tb_octave_value_noise_2d OK");
		else
			$display("tb_octave_value_noise_2d NOT OK");
		$finish;
	end

	initial begin
		#36000000;
		$display("tb_octave_value_noise_2d NOT OK");
		$finish;
	end

endmodule
